>>> rtl/core/motor_relay_sequencer_with_stall_stop_defines.svh
// Assertion helpers used by the checker module.
`ifndef MOTOR_RELAY_SEQUENCER_WITH_STALL_STOP_DEFINES_SVH
`define MOTOR_RELAY_SEQUENCER_WITH_STALL_STOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrs check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrs check failed");

`endif

>>> rtl/core/mrs_pkg.sv
`timescale 1ns / 1ps

package mrs_pkg;

    localparam int TIME_W        = 32;
    localparam int POS_W         = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int STALL_LEVEL_W = 12;
    localparam int MOTION_W      = 3;
    localparam int STOP_W        = 2;
    localparam int RELAY_W       = 6;

    // Parameter defaults
    localparam int unsigned RECLINE_TRAVEL_DEF  = 30000;
    localparam int unsigned HEADREST_TRAVEL_DEF = 20000;
    localparam int unsigned HOME_TOLERANCE_DEF  = 500;
    localparam int unsigned SAMPLE_BITS_DEF     = 12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TIME  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAGGER_TIME = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_TIME   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_TIME     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_TIME    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT    = 3'd6;

    // Configuration reset values
    localparam logic [15:0] RST_SETTLE_TIME  = 16'd300;
    localparam logic [15:0] RST_STAGGER_TIME = 16'd300;
    localparam logic [STALL_LEVEL_W-1:0] RST_STALL_LEVEL = 12'd2048;
    localparam logic [15:0] RST_STALL_TIME   = 16'd500;
    localparam logic [15:0] RST_ARM_TIME     = 16'd1000;
    localparam logic [15:0] RST_ZERO_TIME    = 16'd200;
    localparam logic [15:0] RST_RUN_LIMIT    = 16'd60000;

    // Item kinds
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    // Motion codes
    localparam logic [MOTION_W-1:0] MOT_NONE         = 3'd0;
    localparam logic [MOTION_W-1:0] MOT_RECLINE_UP   = 3'd1;
    localparam logic [MOTION_W-1:0] MOT_RECLINE_DOWN = 3'd2;
    localparam logic [MOTION_W-1:0] MOT_HEAD_UP      = 3'd3;
    localparam logic [MOTION_W-1:0] MOT_HEAD_DOWN    = 3'd4;
    localparam logic [MOTION_W-1:0] MOT_FLATTEN      = 3'd5;

    // Stop event codes
    localparam logic [STOP_W-1:0] STOP_NONE    = 2'd0;
    localparam logic [STOP_W-1:0] STOP_STALL   = 2'd1;
    localparam logic [STOP_W-1:0] STOP_ARRIVAL = 2'd2;
    localparam logic [STOP_W-1:0] STOP_TIMEOUT = 2'd3;

    // Relay vector bit positions
    localparam int REL_A   = 0;
    localparam int REL_B   = 1;
    localparam int REL_C   = 2;
    localparam int REL_D   = 3;
    localparam int REL_EN  = 4;
    localparam int REL_DIR = 5;

    typedef struct packed {
        logic [15:0]              settle_time;
        logic [15:0]              stagger_time;
        logic [STALL_LEVEL_W-1:0] stall_level;
        logic [15:0]              stall_time;
        logic [15:0]              arm_time;
        logic [15:0]              zero_time;
        logic [15:0]              run_limit;
    } t_cfg;

    typedef struct packed {
        logic [RELAY_W-1:0]  relays;
        logic [MOTION_W-1:0] motion;
        logic [STOP_W-1:0]   stop;
        logic [POS_W-1:0]    recline_pos;
        logic [POS_W-1:0]    headrest_pos;
        logic                at_home;
    } t_res;

endpackage

>>> rtl/core/mrs_req_if.sv
`timescale 1ns / 1ps

interface mrs_req_if #(
    parameter int unsigned SAMPLE_BITS = mrs_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   op;
    logic [2:0]             want;
    logic [SAMPLE_BITS-1:0] current_sample;
    logic                   sample_valid;
    logic [31:0]            now_ms;

    modport source (
        output valid, op, want, current_sample, sample_valid, now_ms,
        input  ready
    );

    modport sink (
        input  valid, op, want, current_sample, sample_valid, now_ms,
        output ready
    );
endinterface

>>> rtl/core/mrs_res_if.sv
`timescale 1ns / 1ps

interface mrs_res_if;
    logic        valid;
    logic        ready;
    logic        relay_a;
    logic        relay_b;
    logic        relay_c;
    logic        relay_d;
    logic        headrest_enable;
    logic        headrest_dir;
    logic [2:0]  active_motion;
    logic [1:0]  stop_event;
    logic [15:0] recline_position;
    logic [15:0] headrest_position;
    logic        at_home;

    modport source (
        output valid, relay_a, relay_b, relay_c, relay_d, headrest_enable,
               headrest_dir, active_motion, stop_event, recline_position,
               headrest_position, at_home,
        input  ready
    );

    modport sink (
        input  valid, relay_a, relay_b, relay_c, relay_d, headrest_enable,
               headrest_dir, active_motion, stop_event, recline_position,
               headrest_position, at_home,
        output ready
    );

    modport mon (
        input valid, ready, relay_a, relay_b, relay_c, relay_d, headrest_enable,
              headrest_dir, active_motion, stop_event, recline_position,
              headrest_position, at_home
    );
endinterface

>>> rtl/core/mrs_cfg_regs.sv
`timescale 1ns / 1ps

module mrs_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mrs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mrs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output mrs_pkg::t_cfg                    o_cfg
);

    mrs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_time  <= mrs_pkg::RST_SETTLE_TIME;
            r_cfg.stagger_time <= mrs_pkg::RST_STAGGER_TIME;
            r_cfg.stall_level  <= mrs_pkg::RST_STALL_LEVEL;
            r_cfg.stall_time   <= mrs_pkg::RST_STALL_TIME;
            r_cfg.arm_time     <= mrs_pkg::RST_ARM_TIME;
            r_cfg.zero_time    <= mrs_pkg::RST_ZERO_TIME;
            r_cfg.run_limit    <= mrs_pkg::RST_RUN_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mrs_pkg::CFG_SETTLE_TIME:  r_cfg.settle_time  <= i_cfg_data;
                mrs_pkg::CFG_STAGGER_TIME: r_cfg.stagger_time <= i_cfg_data;
                mrs_pkg::CFG_STALL_LEVEL:  begin
                    r_cfg.stall_level <= i_cfg_data[mrs_pkg::STALL_LEVEL_W-1:0];
                end
                mrs_pkg::CFG_STALL_TIME:   r_cfg.stall_time   <= i_cfg_data;
                mrs_pkg::CFG_ARM_TIME:     r_cfg.arm_time     <= i_cfg_data;
                mrs_pkg::CFG_ZERO_TIME:    r_cfg.zero_time    <= i_cfg_data;
                mrs_pkg::CFG_RUN_LIMIT:    r_cfg.run_limit    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/mrs_in_stage.sv
`timescale 1ns / 1ps

module mrs_in_stage #(
    parameter int unsigned SAMPLE_BITS = mrs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    mrs_req_if.sink                i_req,
    input  logic                   i_out_can,
    output logic                   o_fire,
    output logic                   o_op,
    output logic [2:0]             o_want,
    output logic [SAMPLE_BITS-1:0] o_sample,
    output logic                   o_sample_valid,
    output logic [31:0]            o_now
);

    logic                   r_vld;
    logic                   r_op;
    logic [2:0]             r_want;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_sample_valid;
    logic [31:0]            r_now;
    logic                   in_xfer;

    // the held item moves on whenever the result register can take it
    assign o_fire      = r_vld && i_out_can;
    assign i_req.ready = !r_vld || i_out_can;
    assign in_xfer     = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (in_xfer) begin
            r_vld <= 1'b1;
        end else if (o_fire) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op           <= i_req.op;
            r_want         <= i_req.want;
            r_sample       <= i_req.current_sample;
            r_sample_valid <= i_req.sample_valid;
            r_now          <= i_req.now_ms;
        end
    end

    assign o_op           = r_op;
    assign o_want         = r_want;
    assign o_sample       = r_sample;
    assign o_sample_valid = r_sample_valid;
    assign o_now          = r_now;

endmodule

>>> rtl/core/mrs_ctrl.sv
`timescale 1ns / 1ps

module mrs_ctrl #(
    parameter int unsigned RECLINE_TRAVEL  = mrs_pkg::RECLINE_TRAVEL_DEF,
    parameter int unsigned HEADREST_TRAVEL = mrs_pkg::HEADREST_TRAVEL_DEF,
    parameter int unsigned HOME_TOLERANCE  = mrs_pkg::HOME_TOLERANCE_DEF,
    parameter int unsigned SAMPLE_BITS     = mrs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic                   i_op,
    input  logic [2:0]             i_want,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_sample_valid,
    input  logic [31:0]            i_now,
    input  mrs_pkg::t_cfg          i_cfg,
    output mrs_pkg::t_res          o_res
);

    localparam int CMP_W = (SAMPLE_BITS > mrs_pkg::STALL_LEVEL_W) ?
                           int'(SAMPLE_BITS) : mrs_pkg::STALL_LEVEL_W;
    localparam logic [mrs_pkg::POS_W-1:0] R_TRAVEL = mrs_pkg::POS_W'(RECLINE_TRAVEL);
    localparam logic [mrs_pkg::POS_W-1:0] H_TRAVEL = mrs_pkg::POS_W'(HEADREST_TRAVEL);
    localparam logic [mrs_pkg::POS_W-1:0] HOME_TOL = mrs_pkg::POS_W'(HOME_TOLERANCE);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SETTLE,
        PH_FIRST,
        PH_RUN
    } t_phase;

    t_phase                               r_phase, n_phase, ph_mid;
    logic [mrs_pkg::MOTION_W-1:0]         r_motion, n_motion;
    logic                                 r_fault, n_fault;
    logic                                 r_arrival, n_arrival;
    logic [mrs_pkg::RELAY_W-1:0]          r_relay, n_relay;
    logic                                 r_over, n_over;
    logic                                 r_zero, n_zero;
    logic [31:0]                          r_req_time, n_req_time;
    logic [31:0]                          r_motor_start, n_motor_start;
    logic [31:0]                          r_over_start, n_over_start;
    logic [31:0]                          r_zero_start, n_zero_start;
    logic [31:0]                          r_track, n_track;
    logic [mrs_pkg::POS_W-1:0]            r_rpos, n_rpos;
    logic [mrs_pkg::POS_W-1:0]            r_hpos, n_hpos;

    logic [mrs_pkg::STOP_W-1:0]           stop;
    logic [31:0]                          elapsed, since_start, step, motor_start;
    logic [16:0]                          second_at;
    logic                                 engage, stalled, arrived, timed_out, latched;
    logic [CMP_W-1:0]                     sample_ext, level_ext;

    function automatic logic [mrs_pkg::POS_W-1:0] move_pos(
        input logic [mrs_pkg::POS_W-1:0] pos,
        input logic [mrs_pkg::POS_W-1:0] travel,
        input logic                      up,
        input logic [31:0]               d
    );
        logic [32:0] sum;
        sum = {17'b0, pos} + {1'b0, d};
        if (up) begin
            return (sum > {17'b0, travel}) ? travel : sum[mrs_pkg::POS_W-1:0];
        end
        return (d > {16'b0, pos}) ? '0 : pos - d[mrs_pkg::POS_W-1:0];
    endfunction

    assign sample_ext = CMP_W'(i_sample);
    assign level_ext  = CMP_W'(i_cfg.stall_level);
    assign elapsed    = i_now - r_req_time;
    assign second_at  = {1'b0, i_cfg.settle_time} + {1'b0, i_cfg.stagger_time};
    assign engage     = (r_phase == PH_SETTLE) && (elapsed >= {16'b0, i_cfg.settle_time});
    // first contact closing restarts the motor clock and the tracking base
    assign motor_start = engage ? i_now : r_motor_start;
    assign since_start = i_now - motor_start;
    assign step        = i_now - (engage ? i_now : r_track);
    assign latched     = r_fault || r_arrival;

    always_comb begin
        n_phase       = r_phase;
        n_motion      = r_motion;
        n_fault       = r_fault;
        n_arrival     = r_arrival;
        n_relay       = r_relay;
        n_over        = r_over;
        n_zero        = r_zero;
        n_req_time    = r_req_time;
        n_motor_start = r_motor_start;
        n_over_start  = r_over_start;
        n_zero_start  = r_zero_start;
        n_track       = r_track;
        n_rpos        = r_rpos;
        n_hpos        = r_hpos;
        ph_mid        = r_phase;
        stop          = mrs_pkg::STOP_NONE;
        stalled       = 1'b0;
        arrived       = 1'b0;
        timed_out     = 1'b0;

        if (i_op == mrs_pkg::OP_REQUEST) begin
            if (i_want <= mrs_pkg::MOT_FLATTEN) begin
                if (i_want == mrs_pkg::MOT_NONE) begin
                    n_fault   = 1'b0;
                    n_arrival = 1'b0;
                end
                if ((i_want == mrs_pkg::MOT_NONE || !latched) && i_want != r_motion) begin
                    n_relay  = r_relay & (mrs_pkg::RELAY_W'(1) << mrs_pkg::REL_DIR);
                    n_motion = mrs_pkg::MOT_NONE;
                    n_phase  = PH_IDLE;
                    if (i_want != mrs_pkg::MOT_NONE) begin
                        if (i_want == mrs_pkg::MOT_HEAD_UP) begin
                            n_relay[mrs_pkg::REL_DIR] = 1'b0;
                        end else if (i_want == mrs_pkg::MOT_HEAD_DOWN ||
                                     i_want == mrs_pkg::MOT_FLATTEN) begin
                            n_relay[mrs_pkg::REL_DIR] = 1'b1;
                        end
                        n_motion   = i_want;
                        n_req_time = i_now;
                        n_phase    = PH_SETTLE;
                        n_zero     = 1'b0;
                    end
                end
            end
        end else if (r_motion != mrs_pkg::MOT_NONE) begin
            if (engage) begin
                case (r_motion)
                    mrs_pkg::MOT_RECLINE_UP:   n_relay[mrs_pkg::REL_A]  = 1'b1;
                    mrs_pkg::MOT_RECLINE_DOWN: n_relay[mrs_pkg::REL_C]  = 1'b1;
                    mrs_pkg::MOT_HEAD_UP,
                    mrs_pkg::MOT_HEAD_DOWN:    n_relay[mrs_pkg::REL_EN] = 1'b1;
                    mrs_pkg::MOT_FLATTEN: begin
                        n_relay[mrs_pkg::REL_C]  = 1'b1;
                        n_relay[mrs_pkg::REL_EN] = 1'b1;
                    end
                    default: ;
                endcase
                n_motor_start = i_now;
                ph_mid        = PH_FIRST;
            end else if (r_phase == PH_FIRST && elapsed >= {15'b0, second_at}) begin
                if (r_motion == mrs_pkg::MOT_RECLINE_DOWN || r_motion == mrs_pkg::MOT_FLATTEN) begin
                    n_relay[mrs_pkg::REL_D] = 1'b1;
                end else if (r_motion == mrs_pkg::MOT_RECLINE_UP) begin
                    n_relay[mrs_pkg::REL_B] = 1'b1;
                end
                ph_mid = PH_RUN;
            end
            n_phase = ph_mid;

            if (ph_mid != PH_SETTLE) begin
                n_track = i_now;
                case (r_motion)
                    mrs_pkg::MOT_RECLINE_UP:   n_rpos = move_pos(r_rpos, R_TRAVEL, 1'b1, step);
                    mrs_pkg::MOT_RECLINE_DOWN: n_rpos = move_pos(r_rpos, R_TRAVEL, 1'b0, step);
                    mrs_pkg::MOT_HEAD_UP:      n_hpos = move_pos(r_hpos, H_TRAVEL, 1'b1, step);
                    mrs_pkg::MOT_HEAD_DOWN:    n_hpos = move_pos(r_hpos, H_TRAVEL, 1'b0, step);
                    mrs_pkg::MOT_FLATTEN: begin
                        n_rpos = move_pos(r_rpos, R_TRAVEL, 1'b0, step);
                        n_hpos = move_pos(r_hpos, H_TRAVEL, 1'b0, step);
                    end
                    default: ;
                endcase

                // overcurrent: a failed reading leaves the timer alone
                if (i_sample_valid) begin
                    if (sample_ext < level_ext) begin
                        n_over = 1'b0;
                    end else if (!r_over) begin
                        n_over       = 1'b1;
                        n_over_start = i_now;
                    end else begin
                        stalled = (i_now - r_over_start) >= {16'b0, i_cfg.stall_time};
                    end
                end

                // arrival: recline and flatten only, and only once armed
                if (!stalled && (r_motion == mrs_pkg::MOT_RECLINE_UP ||
                                 r_motion == mrs_pkg::MOT_RECLINE_DOWN ||
                                 r_motion == mrs_pkg::MOT_FLATTEN) &&
                    since_start >= {16'b0, i_cfg.arm_time}) begin
                    if (!i_sample_valid || i_sample != '0) begin
                        n_zero = 1'b0;
                    end else if (!r_zero) begin
                        n_zero       = 1'b1;
                        n_zero_start = i_now;
                    end else begin
                        arrived = (i_now - r_zero_start) >= {16'b0, i_cfg.zero_time};
                    end
                end

                timed_out = since_start > {16'b0, i_cfg.run_limit};

                if (stalled || arrived || timed_out) begin
                    n_relay  = n_relay & (mrs_pkg::RELAY_W'(1) << mrs_pkg::REL_DIR);
                    n_motion = mrs_pkg::MOT_NONE;
                    n_phase  = PH_IDLE;
                end
                if (stalled) begin
                    n_fault = 1'b1;
                    stop    = mrs_pkg::STOP_STALL;
                end else if (arrived) begin
                    n_arrival = 1'b1;
                    stop      = mrs_pkg::STOP_ARRIVAL;
                    if (r_motion == mrs_pkg::MOT_RECLINE_UP) begin
                        n_rpos = R_TRAVEL;
                    end else begin
                        n_rpos = '0;
                        if (r_motion == mrs_pkg::MOT_FLATTEN) begin
                            n_hpos = '0;
                        end
                    end
                end else if (timed_out) begin
                    n_fault = 1'b1;
                    stop    = mrs_pkg::STOP_TIMEOUT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_motion  <= mrs_pkg::MOT_NONE;
            r_fault   <= 1'b0;
            r_arrival <= 1'b0;
            r_relay   <= '0;
            r_over    <= 1'b0;
            r_zero    <= 1'b0;
            r_rpos    <= '0;
            r_hpos    <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_motion  <= n_motion;
            r_fault   <= n_fault;
            r_arrival <= n_arrival;
            r_relay   <= n_relay;
            r_over    <= n_over;
            r_zero    <= n_zero;
            r_rpos    <= n_rpos;
            r_hpos    <= n_hpos;
        end
    end

    // time stamps are only read once their flag or phase says they are live
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_req_time    <= n_req_time;
            r_motor_start <= n_motor_start;
            r_over_start  <= n_over_start;
            r_zero_start  <= n_zero_start;
            r_track       <= n_track;
        end
    end

    assign o_res.relays       = n_relay;
    assign o_res.motion       = n_motion;
    assign o_res.stop         = stop;
    assign o_res.recline_pos  = n_rpos;
    assign o_res.headrest_pos = n_hpos;
    assign o_res.at_home      = (n_rpos <= HOME_TOL) && (n_hpos <= HOME_TOL);

endmodule

>>> rtl/core/mrs_out_stage.sv
`timescale 1ns / 1ps

module mrs_out_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  mrs_pkg::t_res i_res,
    output logic          o_can,
    mrs_res_if.source     o_res
);

    logic          r_vld;
    mrs_pkg::t_res r_res;

    assign o_can = !r_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_fire) begin
            r_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid             = r_vld;
    assign o_res.relay_a           = r_res.relays[mrs_pkg::REL_A];
    assign o_res.relay_b           = r_res.relays[mrs_pkg::REL_B];
    assign o_res.relay_c           = r_res.relays[mrs_pkg::REL_C];
    assign o_res.relay_d           = r_res.relays[mrs_pkg::REL_D];
    assign o_res.headrest_enable   = r_res.relays[mrs_pkg::REL_EN];
    assign o_res.headrest_dir      = r_res.relays[mrs_pkg::REL_DIR];
    assign o_res.active_motion     = r_res.motion;
    assign o_res.stop_event        = r_res.stop;
    assign o_res.recline_position  = r_res.recline_pos;
    assign o_res.headrest_position = r_res.headrest_pos;
    assign o_res.at_home           = r_res.at_home;

endmodule

>>> rtl/core/motor_relay_sequencer_with_stall_stop.sv
`timescale 1ns / 1ps

// Motor relay sequencer with stall, arrival and timeout stop. Each accepted
// item (a motion request or a timed current update) produces exactly one
// result. One item can be taken every clock while the result side keeps taking:
// the item is captured in an input register, processed combinationally
// against the sequencer state, and its result is captured in an output
// register, which offers it on the result channel. Output backpressure
// stalls the input register and, through it, the request channel.
// Configuration writes take effect on the next edge and should only be made
// with no item in flight.

module motor_relay_sequencer_with_stall_stop #(
    parameter int unsigned RECLINE_TRAVEL  = mrs_pkg::RECLINE_TRAVEL_DEF,
    parameter int unsigned HEADREST_TRAVEL = mrs_pkg::HEADREST_TRAVEL_DEF,
    parameter int unsigned HOME_TOLERANCE  = mrs_pkg::HOME_TOLERANCE_DEF,
    parameter int unsigned SAMPLE_BITS     = mrs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mrs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mrs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    mrs_req_if.sink                          i_req,
    mrs_res_if.source                        o_res
);

    mrs_pkg::t_cfg          cfg;
    mrs_pkg::t_res          res;
    logic                   out_can;
    logic                   fire;
    logic                   op;
    logic [2:0]             want;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   sample_valid;
    logic [31:0]            now;

    mrs_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    mrs_in_stage #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_in (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_req),
        .i_out_can      (out_can),
        .o_fire         (fire),
        .o_op           (op),
        .o_want         (want),
        .o_sample       (sample),
        .o_sample_valid (sample_valid),
        .o_now          (now)
    );

    mrs_ctrl #(
        .RECLINE_TRAVEL  (RECLINE_TRAVEL),
        .HEADREST_TRAVEL (HEADREST_TRAVEL),
        .HOME_TOLERANCE  (HOME_TOLERANCE),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_op           (op),
        .i_want         (want),
        .i_sample       (sample),
        .i_sample_valid (sample_valid),
        .i_now          (now),
        .i_cfg          (cfg),
        .o_res          (res)
    );

    mrs_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_res   (res),
        .o_can   (out_can),
        .o_res   (o_res)
    );

endmodule

>>> rtl/core/mrs_chk.sv
`timescale 1ns / 1ps
`include "motor_relay_sequencer_with_stall_stop_defines.svh"

module mrs_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    mrs_res_if.source i_res
);

    // a held result must keep its stop event, motion and recline position
    `MRS_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res.valid && !i_res.ready, i_res.valid && $stable(i_res.stop_event) && $stable(i_res.recline_position) && $stable(i_res.active_motion))

    // any stop leaves every contact open and no motion selected
    `MRS_ASSERT_IMP(a_stop_drops, i_clk, i_rst_n, i_res.valid && i_res.stop_event != mrs_pkg::STOP_NONE, !i_res.relay_a && !i_res.relay_b && !i_res.relay_c && !i_res.relay_d && !i_res.headrest_enable && i_res.active_motion == mrs_pkg::MOT_NONE)

    // contacts are only ever closed for an active motion
    `MRS_ASSERT_IMP(a_idle_open, i_clk, i_rst_n, i_res.valid && i_res.active_motion == mrs_pkg::MOT_NONE, !i_res.relay_a && !i_res.relay_b && !i_res.relay_c && !i_res.relay_d && !i_res.headrest_enable)

    // second stage contacts follow their first stage partner
    `MRS_ASSERT_IMP(a_stagger_order, i_clk, i_rst_n, i_res.valid && (i_res.relay_b || i_res.relay_d), (!i_res.relay_b || (i_res.relay_a && i_res.active_motion == mrs_pkg::MOT_RECLINE_UP)) && (!i_res.relay_d || i_res.relay_c))

endmodule

bind motor_relay_sequencer_with_stall_stop mrs_chk u_mrs_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_res   (o_res)
);
